### sv/tlbpt_pkg.sv
`timescale 1ns / 1ps

package tlbpt_pkg;

    localparam int ADDR_W  = 16;
    localparam int FRAME_W = 8;

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_RESOLVE
    } state_t;

    typedef struct packed
    {
        logic load_addr;
        logic lookup;
        logic resolve;
        logic clear;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic clear_done;
    } ctrl_status_t;

endpackage

### sv/tlbpt_ctrl.sv
`timescale 1ns / 1ps

module tlbpt_ctrl
    import tlbpt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  ctrl_status_t status,
    output logic         busy,
    output ctrl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load_addr = 1'b1;
                    state_next    = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                busy        = 1'b0;
                cmd.resolve = 1'b1;
                if (start)
                begin
                    cmd.load_addr = 1'b1;
                    state_next    = ST_LOOKUP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

### sv/tlbpt_datapath.sv
`timescale 1ns / 1ps

module tlbpt_datapath
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES  = 16,
    parameter int PAGE_COUNT   = 256,
    parameter int OFFSET_WIDTH = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output ctrl_status_t        status,
    input  logic [ADDR_W-1:0]   vaddr,
    output logic                done,
    output logic [ADDR_W-1:0]   paddr,
    output logic                tlb_hit,
    output logic                page_fault
);

    localparam int PAGE_W = $clog2(PAGE_COUNT);
    localparam int PTR_W  = $clog2(TLB_ENTRIES);
    localparam int FILL_W = $clog2(TLB_ENTRIES + 1);
    localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((32'd1 << OFFSET_WIDTH) - 32'd1);

    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   page_full;
    logic [PAGE_W-1:0]   page;
    logic [ADDR_W-1:0]   offset;

    logic [PAGE_W-1:0]   tlb_tags_reg   [TLB_ENTRIES];
    logic [FRAME_W-1:0]  tlb_frames_reg [TLB_ENTRIES];
    logic [FILL_W-1:0]   fill_count_reg;
    logic [PTR_W-1:0]    ins_ptr_reg;
    logic [TLB_ENTRIES-1:0] hit_vec_reg;
    logic [TLB_ENTRIES-1:0] hit_vec_next;

    logic [FRAME_W:0]    pt_mem [PAGE_COUNT];
    logic [FRAME_W:0]    pt_rdata_reg;
    logic [PAGE_W-1:0]   clr_cnt_reg;
    logic [FRAME_W-1:0]  next_free_reg;

    logic [FRAME_W-1:0]  tlb_frame_sel;
    logic                hit;
    logic                pt_valid;
    logic                fault;
    logic [FRAME_W-1:0]  frame;

    logic [ADDR_W-1:0]   paddr_reg;
    logic                tlb_hit_reg;
    logic                page_fault_reg;
    logic                done_reg;

    assign page_full = addr_reg >> OFFSET_WIDTH;
    assign page      = page_full[PAGE_W-1:0];
    assign offset    = addr_reg & OFF_MASK;

    assign status.clear_done = (clr_cnt_reg == PAGE_W'(PAGE_COUNT - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load_addr)
        begin
            addr_reg <= vaddr;
        end
    end

    // tlb tag compare
    always_comb
    begin
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            hit_vec_next[i] = (FILL_W'(i) < fill_count_reg) && (tlb_tags_reg[i] == page);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_vec_reg <= hit_vec_next;
        end
    end

    // lowest matching slot wins
    always_comb
    begin
        tlb_frame_sel = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec_reg[i])
            begin
                tlb_frame_sel = tlb_frames_reg[i];
            end
        end
    end

    assign hit      = |hit_vec_reg;
    assign pt_valid = pt_rdata_reg[FRAME_W];
    assign fault    = !hit && !pt_valid;

    always_comb
    begin
        if (hit)
        begin
            frame = tlb_frame_sel;
        end
        else if (pt_valid)
        begin
            frame = pt_rdata_reg[FRAME_W-1:0];
        end
        else
        begin
            frame = next_free_reg;
        end
    end

    // page table memory
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            pt_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.resolve && fault)
        begin
            pt_mem[page] <= {1'b1, frame};
        end
        if (cmd.lookup)
        begin
            pt_rdata_reg <= pt_mem[page];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + PAGE_W'(1);
        end
    end

    // tlb fifo insert
    always_ff @(posedge clk)
    begin
        if (cmd.resolve && !hit)
        begin
            tlb_tags_reg[ins_ptr_reg]   <= page;
            tlb_frames_reg[ins_ptr_reg] <= frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            ins_ptr_reg    <= '0;
            next_free_reg  <= '0;
        end
        else if (cmd.resolve)
        begin
            if (!hit)
            begin
                if (ins_ptr_reg == PTR_W'(TLB_ENTRIES - 1))
                begin
                    ins_ptr_reg <= '0;
                end
                else
                begin
                    ins_ptr_reg <= ins_ptr_reg + PTR_W'(1);
                end
                if (fill_count_reg != FILL_W'(TLB_ENTRIES))
                begin
                    fill_count_reg <= fill_count_reg + FILL_W'(1);
                end
            end
            if (fault)
            begin
                next_free_reg <= next_free_reg + FRAME_W'(1);
            end
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.resolve)
        begin
            paddr_reg      <= ADDR_W'((32'(frame) << OFFSET_WIDTH) | 32'(offset));
            tlb_hit_reg    <= hit;
            page_fault_reg <= fault;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.resolve;
        end
    end

    assign done       = done_reg;
    assign paddr      = paddr_reg;
    assign tlb_hit    = tlb_hit_reg;
    assign page_fault = page_fault_reg;

endmodule

### sv/tlb_page_table_translator.sv
`timescale 1ns / 1ps
// channel   signals                                  handshake
// request   start, vaddr                             taken when start && !busy
// result    done, paddr, tlb_hit, page_fault         one-cycle strobe on done
//
// each request passes through a tlb compare state (also reads the page table
// memory) then a resolve state that updates tlb and page table
// the result shows on done the cycle after resolve; a new request is taken in that
// resolve cycle
// after reset busy stays high while the page table is cleared
// the receiver cannot stall, so results never wait

module tlb_page_table_translator
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES  = 16,
    parameter int PAGE_COUNT   = 256,
    parameter int OFFSET_WIDTH = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ADDR_W-1:0] vaddr,
    output logic              done,
    output logic [ADDR_W-1:0] paddr,
    output logic              tlb_hit,
    output logic              page_fault
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    tlbpt_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    tlbpt_datapath
    #(
        .TLB_ENTRIES  (TLB_ENTRIES),
        .PAGE_COUNT   (PAGE_COUNT),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .vaddr      (vaddr),
        .done       (done),
        .paddr      (paddr),
        .tlb_hit    (tlb_hit),
        .page_fault (page_fault)
    );

    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(tlb_hit && page_fault))
        else $error("page fault flagged on a tlb hit");

    a_done_after_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.resolve))
        else $error("result strobe without a resolve cycle");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && cmd.lookup))
        else $error("accepted request did not start a lookup");

    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results closer than two cycles");

endmodule
